/* rtl/core/zesd_pkg.sv */
// Shared types and constants for the zero-escaped string decoder.
// Holds the beat payload structs, status codes and counter sizing.
// No dependencies.
`default_nettype none

package zesd_pkg;

    // Width of the per-string byte counter (4 to 32).
    localparam int COUNT_WIDTH = 16;
    localparam int REPORT_WIDTH = 16;
    localparam int CNT_EXT_W = (COUNT_WIDTH > REPORT_WIDTH) ? COUNT_WIDTH : REPORT_WIDTH;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 1;

    typedef logic [2:0] t_status;

    localparam t_status ST_BUSY    = 3'd0;
    localparam t_status ST_DONE    = 3'd1;
    localparam t_status ST_EMPTY   = 3'd2;
    localparam t_status ST_UNTERM  = 3'd3;
    localparam t_status ST_LONE    = 3'd4;
    localparam t_status ST_BADPAIR = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPLEMENT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_DATA    = 1'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_buffer;
    } t_in;

    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    out_valid;
        t_status                 status;
        logic [REPORT_WIDTH-1:0] consumed_bytes;
    } t_out;

endpackage

`default_nettype wire

/* rtl/core/zero_escaped_string_decoder.sv */
// Top level of the zero-escaped string decoder.
// Depends on zesd_pkg for payload structs, status codes and counter width.
//
// Usage: encoded key bytes enter on the input channel (i_valid / o_stall,
// payload i_data), one beat per byte or per end-of-buffer marker. Every
// accepted input beat yields exactly one result beat on the output channel
// (o_valid / i_stall, payload o_data) carrying the decoded byte, if any, and
// the string status; the byte count comes with status done.
// A beat goes through the input register and then the result register.
// Throughput is one beat per cycle unless the receiver stalls; the only loop
// is the one-bit marker flag and the byte counter, updated as a beat fires.
// When the receiver stalls, the result register holds its beat and the input
// register holds the next one; o_stall rises only when both are full. Reset
// (i_rst_n low, synchronous) empties both registers, clears the string state
// and returns both configuration bits to zero. Configuration (i_cfg_we,
// i_cfg_idx, i_cfg_data) is for the user to write while idle; the block does
// not enforce it. Index 0: complement mode; index 1: suppress decoded data.
`default_nettype none

module zero_escaped_string_decoder (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_stall,
    input  zesd_pkg::t_in                         i_data,
    output logic                                  o_valid,
    input  wire                                   i_stall,
    output zesd_pkg::t_out                        o_data,
    input  wire                                   i_cfg_we,
    input  wire  [zesd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [zesd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import zesd_pkg::*;

    logic                   r_cmode;
    logic                   r_discard;
    logic                   r_in_valid;
    t_in                    r_in;
    logic                   r_out_valid;
    t_out                   r_out;
    logic                   r_pend;
    logic [COUNT_WIDTH-1:0] r_count;

    logic                   n_pend;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CNT_EXT_W-1:0]   cnt_ext;
    logic [7:0]             inv;
    logic [7:0]             esc;
    logic                   out_ready;
    logic                   fire;
    logic                   emit;
    logic [7:0]             val;
    t_status                status;
    logic [REPORT_WIDTH-1:0] report;
    t_out                   n_out;

    assign out_ready = !r_out_valid || !i_stall;
    assign fire      = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    assign inv     = {8{r_cmode}};
    assign esc     = inv ^ 8'h01;
    assign cnt_inc = (r_count != '1) ? r_count + 1'b1 : r_count;
    assign cnt_ext = CNT_EXT_W'(cnt_inc);

    always_comb begin
        status  = ST_BUSY;
        emit    = 1'b0;
        val     = 8'h00;
        report  = '0;
        n_pend  = r_pend;
        n_count = r_count;

        if (r_in.byte_present) begin
            n_count = cnt_inc;
            if (r_pend) begin
                n_pend = 1'b0;
                if (r_in.data_byte == inv) begin
                    status = ST_DONE;
                    report = (cnt_ext > CNT_EXT_W'({REPORT_WIDTH{1'b1}})) ?
                             '1 : cnt_ext[REPORT_WIDTH-1:0];
                end else if (r_in.data_byte == esc) begin
                    if (r_in.end_of_buffer) begin
                        status = ST_UNTERM;
                    end else begin
                        emit = 1'b1;
                    end
                end else begin
                    status = ST_BADPAIR;
                end
            end else if (r_in.data_byte == inv) begin
                n_pend = 1'b1;
                if (r_in.end_of_buffer) begin
                    status = ST_LONE;
                end
            end else if (r_in.end_of_buffer) begin
                status = ST_UNTERM;
            end else begin
                emit = 1'b1;
                val  = r_in.data_byte ^ inv;
            end
        end else if (r_in.end_of_buffer) begin
            if (r_pend) begin
                status = ST_LONE;
            end else if (r_count == '0) begin
                status = ST_EMPTY;
            end else begin
                status = ST_UNTERM;
            end
        end

        // any error, done or buffer end closes the string
        if (status != ST_BUSY || r_in.end_of_buffer) begin
            n_pend  = 1'b0;
            n_count = '0;
        end

        if (r_discard) begin
            emit = 1'b0;
        end

        n_out.out_byte       = emit ? val : 8'h00;
        n_out.out_valid      = emit;
        n_out.status         = status;
        n_out.consumed_bytes = report;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmode     <= 1'b0;
            r_discard   <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_COMPLEMENT_MODE: r_cmode   <= i_cfg_data[0];
                    CFG_DISCARD_DATA:    r_discard <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= fire;
            end
            if (fire) begin
                r_pend  <= n_pend;
                r_count <= n_count;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in <= i_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/zesd_checker.sv */
// Port-level checker for the zero-escaped string decoder, bound to the top.
// Depends on zesd_pkg for payload structs and status codes.
`default_nettype none

module zesd_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             o_valid,
    input  wire                             i_stall,
    input  zesd_pkg::t_out                  o_data
);
    import zesd_pkg::*;

    // output register empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result beat changed");

    // a decoded byte only comes with status in progress
    a_byte_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.out_valid |-> o_data.status == ST_BUSY)
        else $error("decoded byte with terminal status");

    // byte count only reported with done
    a_count_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_DONE |-> o_data.consumed_bytes == '0)
        else $error("byte count outside done");

    // a done string consumed at least the terminator pair
    a_done_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status == ST_DONE |-> o_data.consumed_bytes >= 2)
        else $error("done with fewer than two bytes");

endmodule

bind zero_escaped_string_decoder zesd_checker u_zesd_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for zero_escaped_string_decoder: queues encoded key beats,
// predicts every result beat from a local decoder model and checks them in order.
// Depends on zesd_pkg and the decoder RTL.

module testbench;

    import zesd_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_GAP        = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CHOKE_LEN      = 120;
    localparam int CHOKE_EVERY    = 700;
    localparam int CHOKE_AT       = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_stall;
    t_in                  i_data     = '0;
    logic                 o_valid;
    logic                 i_stall    = 1'b0;
    t_out                 o_data;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // decoder model state and its copy of the registers
    logic                   cfg_invert = 1'b0;
    logic                   cfg_drop   = 1'b0;
    logic                   mark_pend  = 1'b0;
    logic [COUNT_WIDTH-1:0] str_len    = '0;

    t_in  stim_q[$];
    t_out decoded_q[$];
    t_out want;

    int   err_count    = 0;
    int   results_seen = 0;
    int   send_wait    = 0;
    int   rcv_wait     = 0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    logic send_burst   = 1'b0;
    logic rcv_burst    = 1'b0;

    zero_escaped_string_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic int draw_gap(input logic fast);
        return fast ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [7:0] rand_literal(input logic [7:0] mk);
        logic [7:0] b;
        do b = 8'($urandom); while (b == mk);
        return b;
    endfunction

    // Advance the string state by one beat and queue the decoded result.
    task automatic decode_beat(input t_in beat);
        logic [7:0]           flip;
        logic [7:0]           mk;
        logic [7:0]           esc;
        logic                 emit;
        logic [7:0]           val;
        logic [CNT_EXT_W-1:0] len_ext;
        t_out                 res;
        flip = cfg_invert ? 8'hFF : 8'h00;
        mk   = flip;
        esc  = flip ^ 8'h01;
        emit = 1'b0;
        val  = 8'h00;
        res  = '0;
        res.status = ST_BUSY;
        if (beat.byte_present) begin
            if (str_len != '1)
                str_len++;
            if (mark_pend) begin
                mark_pend = 1'b0;
                if (beat.data_byte == mk) begin
                    res.status = ST_DONE;
                    len_ext = str_len;
                    if ((len_ext >> REPORT_WIDTH) != 0)
                        res.consumed_bytes = '1;
                    else
                        res.consumed_bytes = len_ext[REPORT_WIDTH-1:0];
                end else if (beat.data_byte == esc) begin
                    if (beat.end_of_buffer)
                        res.status = ST_UNTERM;
                    else
                        emit = 1'b1;
                end else begin
                    res.status = ST_BADPAIR;
                end
            end else if (beat.data_byte == mk) begin
                mark_pend = 1'b1;
                if (beat.end_of_buffer)
                    res.status = ST_LONE;
            end else if (beat.end_of_buffer) begin
                res.status = ST_UNTERM;
            end else begin
                emit = 1'b1;
                val  = beat.data_byte ^ flip;
            end
        end else if (beat.end_of_buffer) begin
            if (mark_pend)
                res.status = ST_LONE;
            else if (str_len == '0)
                res.status = ST_EMPTY;
            else
                res.status = ST_UNTERM;
        end
        if (res.status != ST_BUSY || beat.end_of_buffer) begin
            mark_pend = 1'b0;
            str_len   = '0;
        end
        if (cfg_drop)
            emit = 1'b0;
        res.out_valid = emit;
        res.out_byte  = emit ? val : 8'h00;
        decoded_q.insert(decoded_q.size(), res);
    endtask

    task automatic queue_beat(input logic [7:0] b, input logic present, input logic eob);
        t_in beat;
        beat.data_byte     = b;
        beat.byte_present  = present;
        beat.end_of_buffer = eob;
        stim_q.insert(stim_q.size(), beat);
    endtask

    // Mostly well-formed strings with random content, plus broken strings and noise.
    task automatic queue_random(input int count);
        int         base;
        int         n;
        logic [7:0] mk;
        logic [7:0] esc;
        logic [7:0] b;
        base = stim_q.size();
        mk   = cfg_invert ? 8'hFF : 8'h00;
        esc  = mk ^ 8'h01;
        while (stim_q.size() - base < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 8);
                    repeat (n) begin
                        if ($urandom_range(0, 3) == 0) begin
                            queue_beat(mk, 1'b1, 1'b0);
                            queue_beat(esc, 1'b1, 1'b0);
                        end else begin
                            queue_beat(rand_literal(mk), 1'b1, 1'b0);
                        end
                        if ($urandom_range(0, 11) == 0)
                            queue_beat(8'($urandom), 1'b0, 1'b0);
                    end
                    queue_beat(mk, 1'b1, 1'b0);
                    case ($urandom_range(0, 3))
                        0, 1: queue_beat(mk, 1'b1, 1'b0);
                        2: queue_beat(mk, 1'b1, 1'b1);
                        default: begin
                            queue_beat(mk, 1'b1, 1'b0);
                            queue_beat(8'($urandom), 1'b0, 1'b1);
                        end
                    endcase
                end
                7: begin
                    repeat ($urandom_range(0, 3))
                        queue_beat(rand_literal(mk), 1'b1, 1'b0);
                    case ($urandom_range(0, 5))
                        0: queue_beat(rand_literal(mk), 1'b1, 1'b1);
                        1: queue_beat(mk, 1'b1, 1'b1);
                        2: begin
                            queue_beat(mk, 1'b1, 1'b0);
                            queue_beat(8'($urandom), 1'b0, 1'b1);
                        end
                        3: begin
                            queue_beat(mk, 1'b1, 1'b0);
                            queue_beat(esc, 1'b1, 1'b1);
                        end
                        4: begin
                            do b = 8'($urandom); while (b == mk || b == esc);
                            queue_beat(mk, 1'b1, 1'b0);
                            queue_beat(b, 1'b1, 1'($urandom_range(0, 1)));
                        end
                        default: queue_beat(8'($urandom), 1'b0, 1'b1);
                    endcase
                end
                8: begin
                    repeat ($urandom_range(1, 4)) begin
                        case ($urandom_range(0, 2))
                            0: b = mk;
                            1: b = esc;
                            default: b = 8'($urandom);
                        endcase
                        queue_beat(b, $urandom_range(0, 3) != 0, $urandom_range(0, 7) == 0);
                    end
                end
                default: queue_beat(8'($urandom), 1'b0, 1'b0);
            endcase
        end
    endtask

    // No beat in flight and every result back; string state may still be open.
    task automatic wait_idle;
        do @(negedge i_clk); while (stim_q.size() != 0 || i_valid || decoded_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_COMPLEMENT_MODE)
            cfg_invert = val[0];
        else if (idx == CFG_DISCARD_DATA)
            cfg_drop = val[0];
        @(negedge i_clk);
    endtask

    // input side: one beat offered at a time, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (i_valid && !o_stall) begin
                decode_beat(i_data);
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_wait = draw_gap(send_burst);
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    i_valid <= 1'b0;
                end else if (stim_q.size() != 0) begin
                    i_valid <= 1'b1;
                    i_data  <= stim_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check each beat, then stall a random while; long hold now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("result %0d not expected: %p", results_seen, o_data);
                end else begin
                    want = decoded_q.pop_front();
                    if (o_data.out_byte !== want.out_byte || o_data.out_valid !== want.out_valid ||
                        o_data.status !== want.status ||
                        o_data.consumed_bytes !== want.consumed_bytes) begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT)
                            $display("res %0d exp/act byte %h/%h vld %b/%b st %0d/%0d cnt %0d/%0d",
                                     results_seen,
                                     want.out_byte, o_data.out_byte, want.out_valid,
                                     o_data.out_valid, want.status, o_data.status,
                                     want.consumed_bytes, o_data.consumed_bytes);
                    end
                end
                results_seen++;
                if (results_seen % CHOKE_EVERY == CHOKE_AT)
                    hold_left = CHOKE_LEN;
                if ($urandom_range(0, 39) == 0)
                    rcv_burst = !rcv_burst;
                rcv_wait = draw_gap(rcv_burst);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rcv_wait > 0) begin
                rcv_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // plain mode: literals, escaped zero, terminator, then each way a string can fail
        queue_beat(8'h41, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h01, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'h7F, 1'b1, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h01, 1'b1, 1'b1);
        queue_beat(8'h55, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h80, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b1);
        queue_beat(8'hAA, 1'b0, 1'b0);
        queue_random(250);
        wait_idle();

        write_reg(CFG_COMPLEMENT_MODE, 1'b1);
        queue_beat(8'h12, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'hFE, 1'b1, 1'b0);
        queue_beat(8'h00, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b0);
        queue_random(250);
        wait_idle();

        write_reg(CFG_DISCARD_DATA, 1'b1);
        queue_random(250);
        wait_idle();

        write_reg(CFG_COMPLEMENT_MODE, 1'b0);
        queue_random(200);
        wait_idle();

        write_reg(CFG_DISCARD_DATA, 1'b0);
        queue_random(250);
        wait_idle();

        write_reg(CFG_COMPLEMENT_MODE, 1'b1);
        queue_random(200);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/zesd_pkg.sv
rtl/core/zero_escaped_string_decoder.sv
rtl/core/zesd_checker.sv
tb/testbench.sv
